@@ hdl/ipv4dq_pkg.sv @@
`default_nettype none

package ipv4dq_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned OCTET_W = 9;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned DOTS_W  = 2;

    localparam logic [CHAR_W-1:0]  CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0]  CH_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CH_NINE  = 8'd57;

    localparam logic [OCTET_W-1:0] OCTET_MAX   = 9'd255;
    localparam logic [OCTET_W-1:0] OCTET_SAT   = 9'd256;
    localparam logic [DOTS_W-1:0]  DOTS_NEEDED = 2'd3;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_TEXT  = 2'd1,
        PH_TRAIL = 2'd2
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } t_item;

    typedef struct packed {
        logic valid;
        logic address_ok;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/ipv4dq_in_reg.sv @@
`default_nettype none

module ipv4dq_in_reg
    import ipv4dq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ hdl/ipv4dq_scan.sv @@
`default_nettype none

module ipv4dq_scan
    import ipv4dq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    output t_result    o_result
);

    t_phase             r_phase, n_phase;
    logic [OCTET_W-1:0] r_octet, n_octet;
    logic               r_starts_zero, n_starts_zero;
    logic [DOTS_W-1:0]  r_dots, n_dots;
    logic               r_digit_exp, n_digit_exp;
    logic               r_err, n_err;

    logic               is_space;
    logic               is_digit;
    logic               is_dot;
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  char_off;
    logic [11:0]        octet_acc;
    logic               final_err;

    function automatic logic octet_bad(input logic de, input logic [OCTET_W-1:0] val,
                                       input logic sz);
        octet_bad = de || (val > OCTET_MAX) || ((val != '0) && sz);
    endfunction

    always_comb begin
        is_space  = (i_item.char_code == CH_SPACE);
        is_dot    = (i_item.char_code == CH_DOT);
        is_digit  = (i_item.char_code >= CH_ZERO) && (i_item.char_code <= CH_NINE);
        char_off  = i_item.char_code - CH_ZERO;
        digit     = char_off[DIGIT_W-1:0];
        // times ten as two shifts
        octet_acc = {r_octet, 3'b000} + {2'b00, r_octet, 1'b0} + {8'd0, digit};

        n_phase       = r_phase;
        n_octet       = r_octet;
        n_starts_zero = r_starts_zero;
        n_dots        = r_dots;
        n_digit_exp   = r_digit_exp;
        n_err         = r_err;
        final_err     = 1'b0;
        o_result      = '0;

        if (i_step) begin
            if (is_space) begin
                if (r_phase == PH_TEXT) begin
                    n_phase = PH_TRAIL;
                end
            end else begin
                if (r_phase == PH_TRAIL) begin
                    n_err = 1'b1;
                end
                n_phase = PH_TEXT;
                if (is_digit) begin
                    if (r_digit_exp) begin
                        n_starts_zero = (digit == '0);
                    end
                    n_digit_exp = 1'b0;
                    if (octet_acc > {3'b000, OCTET_SAT}) begin
                        n_octet = OCTET_SAT;
                    end else begin
                        n_octet = octet_acc[OCTET_W-1:0];
                    end
                end else if (is_dot) begin
                    if (octet_bad(r_digit_exp, r_octet, r_starts_zero)) begin
                        n_err = 1'b1;
                    end
                    if (r_dots == DOTS_NEEDED) begin
                        n_err = 1'b1;
                    end else begin
                        n_dots = r_dots + 1'b1;
                    end
                    n_octet       = '0;
                    n_starts_zero = 1'b0;
                    n_digit_exp   = 1'b1;
                end else begin
                    n_err = 1'b1;
                end
            end

            if (i_item.end_of_text) begin
                final_err = n_err || (n_phase == PH_LEAD)
                          || octet_bad(n_digit_exp, n_octet, n_starts_zero)
                          || (n_dots != DOTS_NEEDED);
                o_result.valid      = 1'b1;
                o_result.address_ok = !final_err;
                // back to the reset state for the next string
                n_phase       = PH_LEAD;
                n_octet       = '0;
                n_starts_zero = 1'b0;
                n_dots        = '0;
                n_digit_exp   = 1'b1;
                n_err         = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LEAD;
            r_octet       <= '0;
            r_starts_zero <= 1'b0;
            r_dots        <= '0;
            r_digit_exp   <= 1'b1;
            r_err         <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_octet       <= n_octet;
            r_starts_zero <= n_starts_zero;
            r_dots        <= n_dots;
            r_digit_exp   <= n_digit_exp;
            r_err         <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ipv4dq_out_reg.sv @@
`default_nettype none

module ipv4dq_out_reg
    import ipv4dq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_valid,
    output logic         o_address_ok
);

    logic r_valid, n_valid;
    logic r_ok;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_ok <= i_result.address_ok;
        end
    end

    assign o_valid      = r_valid;
    assign o_address_ok = r_ok;

endmodule

`default_nettype wire

@@ hdl/ipv4_dotted_quad_validator_top.sv @@
// IPv4 dotted-decimal address checker, one text byte per transaction.
// Input channel: i_in_valid / o_in_stall carry i_char_code and i_end_of_text;
// the final byte of a string has i_end_of_text set. Leading and trailing
// spaces are skipped; the rest must be four octets of at most 255 split by
// three dots, with no leading zero on a nonzero octet.
// Output channel: o_out_valid / i_out_stall carry o_address_ok, one
// transaction per string, produced by its end-marked byte only.
// Path: an accepted byte is held in the input register; when it advances,
// the scan state updates and a final byte's result enters the result register.
// Throughput: one byte per cycle unless o_in_stall is high, set by the scan
// state update between the input register and the result register.
// While the receiver stalls and a result is waiting, non-final bytes keep
// flowing; an end-marked byte waits in the input register, and o_in_stall
// rises, until the result register is free.
// Reset (synchronous, i_rst_n low) empties both registers and returns the
// scanner to its start-of-string state; the next byte begins a new string.
`default_nettype none

module ipv4_dotted_quad_validator_top
    import ipv4dq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_end_of_text,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_address_ok
);

    t_item   in_item;
    t_item   held_item;
    t_result result;
    logic    held_valid;
    logic    advance;
    logic    accept;

    assign in_item.char_code   = i_char_code;
    assign in_item.end_of_text = i_end_of_text;

    // only a final byte needs room in the result register
    assign advance    = held_valid
                      && (!held_item.end_of_text || !o_out_valid || !i_out_stall);
    assign o_in_stall = held_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    ipv4dq_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    ipv4dq_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (held_item),
        .o_result (result)
    );

    ipv4dq_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (result),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_address_ok (o_address_ok)
    );

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |=> o_out_valid)
        else $error("result of a final byte did not reach the output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !result.valid)
        else $error("waiting result would be overwritten");

    a_result_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |-> (advance && held_item.end_of_text))
        else $error("result produced without a final byte");

    a_stall_needs_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (held_item.end_of_text && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked final byte");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
    import ipv4dq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic [CHAR_W-1:0] i_char_code   = '0;
    logic              i_end_of_text = 1'b0;
    logic              i_out_stall   = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_address_ok;

    ipv4_dotted_quad_validator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_address_ok  (o_address_ok)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // text bytes waiting to be offered, and verdicts waiting to come out
    t_item       byte_q[$];
    logic        ok_expected_q[$];
    int unsigned queued_bytes   = 0;
    int unsigned sent_count     = 0;
    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 15;
    int unsigned recv_stall_pct = 74;
    int unsigned hold_left      = 0;
    int unsigned hold_at        = 400;
    string       symbol_set     = "0123456789. ";
    t_item       next_byte;
    logic        want_ok;

    // scanner state mirrored from the block
    t_phase             scan_ph;
    logic [OCTET_W-1:0] octet_val;
    logic               lead_zero;
    logic [DOTS_W-1:0]  dot_cnt;
    logic               need_digit;
    logic               addr_bad;

    function void clear_scan();
        scan_ph    = PH_LEAD;
        octet_val  = '0;
        lead_zero  = 1'b0;
        dot_cnt    = '0;
        need_digit = 1'b1;
        addr_bad   = 1'b0;
    endfunction

    function void end_octet_check();
        if (need_digit) begin
            addr_bad = 1'b1;
        end else begin
            if (octet_val > OCTET_MAX) addr_bad = 1'b1;
            if (octet_val != 0 && lead_zero) addr_bad = 1'b1;
        end
    endfunction

    function void predict_byte(input t_item it);
        int unsigned grown;
        if (it.char_code == CH_SPACE) begin
            if (scan_ph == PH_TEXT) scan_ph = PH_TRAIL;
        end else begin
            // anything after trailing spaces means an inner space
            if (scan_ph == PH_TRAIL) addr_bad = 1'b1;
            scan_ph = PH_TEXT;
            if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
                if (need_digit) lead_zero = (it.char_code == CH_ZERO);
                need_digit = 1'b0;
                grown = octet_val * 10 + (it.char_code - CH_ZERO);
                octet_val = (grown > OCTET_SAT) ? OCTET_SAT : grown[OCTET_W-1:0];
            end else if (it.char_code == CH_DOT) begin
                end_octet_check();
                if (dot_cnt >= DOTS_NEEDED) addr_bad = 1'b1;
                else dot_cnt = dot_cnt + 1'b1;
                octet_val  = '0;
                lead_zero  = 1'b0;
                need_digit = 1'b1;
            end else begin
                addr_bad = 1'b1;
            end
        end
        if (it.end_of_text) begin
            if (scan_ph == PH_LEAD) addr_bad = 1'b1;
            end_octet_check();
            if (dot_cnt != DOTS_NEEDED) addr_bad = 1'b1;
            ok_expected_q.push_back(!addr_bad);
            clear_scan();
        end
    endfunction

    function void note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endfunction

    task automatic add_text(ref logic [7:0] b[$], input string s);
        for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    endtask

    task automatic queue_string(input logic [7:0] b[$]);
        t_item it;
        foreach (b[i]) begin
            it.char_code   = b[i];
            it.end_of_text = (i == b.size() - 1);
            byte_q.push_back(it);
        end
        queued_bytes += b.size();
    endtask

    task automatic queue_text(input string s);
        logic [7:0] b[$];
        add_text(b, s);
        queue_string(b);
    endtask

    function automatic string octet_text();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 85) return $sformatf("%0d", $urandom_range(255));
        if (pick < 90) return {"0", $sformatf("%0d", $urandom_range(99))};
        if (pick < 92) return "00";
        if (pick < 93) return "000";
        if (pick < 97) return $sformatf("%0d", $urandom_range(999, 256));
        return $sformatf("%0d", $urandom_range(99999, 1000));
    endfunction

    task automatic queue_random_string();
        logic [7:0]  b[$];
        int unsigned pick;
        int unsigned pos;
        pick = $urandom_range(99);
        if (pick < 10) begin
            repeat ($urandom_range(8, 1)) begin
                if ($urandom_range(2) == 0) b.push_back(8'($urandom_range(255)));
                else b.push_back(symbol_set[$urandom_range(symbol_set.len() - 1)]);
            end
        end else if (pick < 13) begin
            repeat ($urandom_range(4, 1)) b.push_back(CH_SPACE);
        end else begin
            repeat ($urandom_range(2)) b.push_back(CH_SPACE);
            add_text(b, octet_text());
            repeat (3) add_text(b, {".", octet_text()});
            repeat ($urandom_range(2)) b.push_back(CH_SPACE);
            // break some of the well-formed strings
            pick = $urandom_range(99);
            pos  = $urandom_range(b.size() - 1);
            if (pick < 10) b[pos] = 8'($urandom_range(255));
            else if (pick < 18) b.insert(pos, CH_SPACE);
            else if (pick < 26 && b.size() > 1) b.delete(pos);
            else if (pick < 33) b.insert(pos, CH_DOT);
            else if (pick < 40) add_text(b, {".", octet_text()});
        end
        queue_string(b);
    endtask

    task automatic wait_sent();
        @(negedge i_clk);
        while (byte_q.size() != 0 || i_in_valid) @(negedge i_clk);
    endtask

    // sender: a byte held under stall stays put
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (i_in_valid) begin
                    next_byte.char_code   = i_char_code;
                    next_byte.end_of_text = i_end_of_text;
                    predict_byte(next_byte);
                    sent_count <= sent_count + 1;
                end
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = byte_q.pop_front();
                    i_char_code   <= next_byte.char_code;
                    i_end_of_text <= next_byte.end_of_text;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (sent_count >= hold_at) begin
                hold_left <= 160;
                hold_at   <= hold_at + 900;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (ok_expected_q.size() == 0) begin
                    note_error($sformatf("unexpected transaction: address_ok=%0b", o_address_ok));
                end else begin
                    want_ok = ok_expected_q.pop_front();
                    if (o_address_ok !== want_ok)
                        note_error($sformatf("address_ok mismatch: expected %0b, got %0b",
                                             want_ok, o_address_ok));
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        clear_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_text("0.0.0.0");
        queue_text(" 255.255.255.255  ");
        queue_text("256.1.1.1");
        queue_text("01.2.3.4");
        queue_text("00.0.0.0");
        queue_text("   ");
        queue_text("1.2 .3.4");
        queue_text(".1.2.3");
        queue_text("1..2.3");
        queue_text("1.2.3.");
        queue_text("1.2.3.4.5");
        queue_text("99999.1.1.1");
        queue_text("7");
        queue_string('{8'h31, 8'h00, 8'h2e, 8'hff});
        queue_text("9.8.7.6 x");

        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: begin send_idle_pct = 15; recv_stall_pct = 74; end
                1: begin send_idle_pct = 74; recv_stall_pct = 15; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            hold_at_goal: begin
                int unsigned goal;
                goal = queued_bytes + 510;
                while (queued_bytes < goal) queue_random_string();
            end
            wait_sent();
        end

        while (ok_expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/ipv4dq_pkg.sv
hdl/ipv4dq_in_reg.sv
hdl/ipv4dq_scan.sv
hdl/ipv4dq_out_reg.sv
hdl/ipv4_dotted_quad_validator_top.sv
dv/tb.sv
